// File: hw/rtl/dsfr_pkg.sv
// shared types, codes and constants of the framed serial receiver
`default_nettype none

package dsfr_pkg;

    // frame buffer geometry
    localparam int BUF_DEPTH = 1024;
    localparam int BUF_AW    = $clog2(BUF_DEPTH);
    localparam int CNT_W     = BUF_AW + 1;

    // fixed framing positions and target codes
    localparam int          HDR_END      = 10;
    localparam logic [7:0]  TGT_BCAST    = 8'hFF;
    localparam logic [7:0]  TGT_ALT      = 8'd200;
    localparam logic [7:0]  TGT_UNIT_MAX = 8'd64;
    localparam logic [7:0]  ZERO_BYTE    = 8'h00;

    // configuration register map (word index)
    localparam int          CFG_AW           = 5;
    localparam logic [2:0]  REG_ABORT_TIME   = 3'd0;
    localparam logic [2:0]  REG_DLE_CODE     = 3'd1;
    localparam logic [2:0]  REG_STX_CODE     = 3'd2;
    localparam logic [2:0]  REG_ETX_CODE     = 3'd3;
    localparam logic [2:0]  REG_GROUP_TARGET = 3'd4;
    localparam logic [2:0]  REG_OBJECT_FIRST = 3'd5;
    localparam logic [2:0]  REG_OBJECT_COUNT = 3'd6;

    // configuration reset values
    localparam logic [15:0] RST_ABORT_TIME   = 16'd2000;
    localparam logic [7:0]  RST_DLE_CODE     = 8'd16;
    localparam logic [7:0]  RST_STX_CODE     = 8'd2;
    localparam logic [7:0]  RST_ETX_CODE     = 8'd3;
    localparam logic [7:0]  RST_GROUP_TARGET = 8'd128;
    localparam logic [7:0]  RST_OBJECT_FIRST = 8'd0;
    localparam logic [7:0]  RST_OBJECT_COUNT = 8'd0;

    // packed widths of the stream words
    localparam int IN_DATA_W  = 24;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 40;

    typedef enum logic [1:0] {
        ACT_BYTE    = 2'd0,
        ACT_TICK    = 2'd1,
        ACT_RELEASE = 2'd2,
        ACT_READ    = 2'd3
    } t_action;

    typedef struct packed {
        logic [15:0] abort_time;
        logic [7:0]  dle_code;
        logic [7:0]  stx_code;
        logic [7:0]  etx_code;
        logic [7:0]  group_target;
        logic [7:0]  object_first;
        logic [7:0]  object_count;
    } t_cfg;

    typedef struct packed {
        logic [7:0]        read_data;
        logic              overflow;
        logic              stale_dropped;
        logic [CNT_W-1:0]  frame_length;
        logic              frame_ready;
        logic [BUF_AW-1:0] byte_position;
        logic              byte_accepted;
    } t_result;

endpackage

`default_nettype wire

// File: hw/rtl/dsfr_rx_core.sv
// frame tracking, frame buffer and first result stage of the receiver
`default_nettype none

module dsfr_rx_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire dsfr_pkg::t_cfg                i_cfg,
    input  wire logic                          i_take,
    input  wire dsfr_pkg::t_action             i_action,
    input  wire logic [7:0]                    i_rx_byte,
    input  wire logic [dsfr_pkg::BUF_AW-1:0]   i_read_index,
    input  wire logic                          i_pop,
    output logic                               o_res_valid,
    output dsfr_pkg::t_result                  o_res
);
    import dsfr_pkg::*;

    // frame state
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_held, n_held;
    logic [31:0]       r_now, n_now;
    logic [31:0]       r_held_tick, n_held_tick;
    logic [7:0]        r_len_hi, n_len_hi;
    logic [7:0]        r_len_lo, n_len_lo;
    logic [7:0]        r_prev1, n_prev1;
    logic [7:0]        r_prev2, n_prev2;
    logic [7:0]        r_buf0, n_buf0;

    // first result stage
    logic              r_a_valid;
    t_result           r_a_res, n_a_res;
    logic              r_a_read;
    logic              r_a_zero;

    // frame buffer, position zero is read from r_buf0
    logic [7:0]        r_mem [BUF_DEPTH];
    logic [7:0]        r_q;

    logic              mem_we;
    logic [BUF_AW-1:0] at;
    logic [CNT_W-1:0]  at_cnt;
    logic [31:0]       age;
    logic              aged;
    logic              target_ok;
    logic [16:0]       trail_pos;
    logic              acc, stale, ovf;
    logic [BUF_AW-1:0] pos;

    // target filter on byte four
    always_comb begin
        target_ok = (i_rx_byte == TGT_BCAST) || (i_rx_byte == TGT_ALT)
                 || ((i_rx_byte != ZERO_BYTE) && (i_rx_byte <= TGT_UNIT_MAX))
                 || (i_rx_byte == i_cfg.group_target)
                 || ((i_rx_byte >= i_cfg.object_first)
                     && ({1'b0, i_rx_byte} < ({1'b0, i_cfg.object_first}
                                              + {1'b0, i_cfg.object_count})));
    end

    assign age       = r_now - r_held_tick;
    assign aged      = (i_cfg.abort_time != 16'd0) && (age >= {16'd0, i_cfg.abort_time});
    assign trail_pos = {1'b0, r_len_hi, r_len_lo} + 17'(HDR_END);

    // next state and result of one word
    always_comb begin
        n_count     = r_count;
        n_held      = r_held;
        n_now       = r_now;
        n_held_tick = r_held_tick;
        n_len_hi    = r_len_hi;
        n_len_lo    = r_len_lo;
        n_prev1     = r_prev1;
        n_prev2     = r_prev2;
        n_buf0      = r_buf0;
        acc         = 1'b0;
        stale       = 1'b0;
        ovf         = 1'b0;
        pos         = '0;
        mem_we      = 1'b0;
        at_cnt      = r_count;

        if (i_take) begin
            unique case (i_action)
                ACT_BYTE: begin
                    // age out a held frame before looking at the byte
                    if (r_held && aged) begin
                        n_count     = '0;
                        n_held      = 1'b0;
                        n_held_tick = r_now;
                        stale       = 1'b1;
                        at_cnt      = '0;
                    end
                    if (!r_held || aged) begin
                        mem_we  = 1'b1;
                        pos     = at;
                        n_prev2 = r_prev1;
                        n_prev1 = i_rx_byte;
                        if (at == BUF_AW'(6)) n_len_hi = i_rx_byte;
                        if (at == BUF_AW'(7)) n_len_lo = i_rx_byte;
                        if (at == '0)         n_buf0   = i_rx_byte;

                        if ((at >= BUF_AW'(HDR_END)) && (17'(at) == trail_pos)) begin
                            // trailer check at the last byte
                            acc = 1'b1;
                            if ((r_prev2 != i_cfg.dle_code) || (r_prev1 != i_cfg.etx_code)) begin
                                n_count = CNT_W'(1);
                                n_buf0  = i_rx_byte;
                                pos     = '0;
                            end else begin
                                n_count     = CNT_W'(at) + CNT_W'(1);
                                n_held      = 1'b1;
                                n_held_tick = r_now;
                            end
                        end else if ((at == '0) && (i_rx_byte != i_cfg.dle_code)) begin
                            n_count = '0;
                        end else if ((at == BUF_AW'(1)) && (i_rx_byte != i_cfg.stx_code)) begin
                            n_count = '0;
                            n_buf0  = i_rx_byte;
                            pos     = '0;
                        end else if (((at == BUF_AW'(3)) && (i_rx_byte != ZERO_BYTE))
                                  || ((at == BUF_AW'(4)) && !target_ok)) begin
                            // header resync keeps this byte as a new start
                            n_count = CNT_W'(1);
                            n_buf0  = i_rx_byte;
                            pos     = '0;
                            acc     = 1'b1;
                        end else if (at == BUF_AW'(BUF_DEPTH - 1)) begin
                            n_count = '0;
                            ovf     = 1'b1;
                        end else begin
                            n_count = CNT_W'(at) + CNT_W'(1);
                            acc     = 1'b1;
                        end
                    end
                end
                ACT_TICK: begin
                    n_now = r_now + 32'd1;
                end
                ACT_RELEASE: begin
                    if (r_held) begin
                        n_held  = 1'b0;
                        n_count = '0;
                    end
                end
                ACT_READ: begin
                    // buffer read goes through the memory port
                end
                default: begin
                end
            endcase
        end

        n_a_res               = '0;
        n_a_res.byte_accepted = acc;
        n_a_res.byte_position = pos;
        n_a_res.frame_ready   = n_held;
        n_a_res.frame_length  = n_held ? n_count : '0;
        n_a_res.stale_dropped = stale;
        n_a_res.overflow      = ovf;
    end

    // write position never exceeds the buffer while collecting
    assign at = at_cnt[BUF_AW-1:0];

    // frame state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_held      <= 1'b0;
            r_now       <= '0;
            r_held_tick <= '0;
        end else begin
            r_count     <= n_count;
            r_held      <= n_held;
            r_now       <= n_now;
            r_held_tick <= n_held_tick;
        end
    end

    // captured header and trailer bytes
    always_ff @(posedge i_clk) begin
        r_len_hi <= n_len_hi;
        r_len_lo <= n_len_lo;
        r_prev1  <= n_prev1;
        r_prev2  <= n_prev2;
        r_buf0   <= n_buf0;
    end

    // frame buffer write and registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[at] <= i_rx_byte;
        end
        if (i_take && (i_action == ACT_READ)) begin
            r_q <= r_mem[i_read_index];
        end
    end

    // first result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_take) begin
            r_a_valid <= 1'b1;
        end else if (i_pop) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_a_res  <= n_a_res;
            r_a_read <= (i_action == ACT_READ);
            r_a_zero <= (i_read_index == '0);
        end
    end

    // read data joins the result here
    always_comb begin
        o_res = r_a_res;
        if (r_a_read) begin
            o_res.read_data = r_a_zero ? r_buf0 : r_q;
        end else begin
            o_res.read_data = '0;
        end
    end

    assign o_res_valid = r_a_valid;

    // a held frame always contains at least a full header and trailer
    a_held_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held |-> (r_count >= CNT_W'(HDR_END + 1)))
        else $error("held frame shorter than header and trailer");

    // the count only reaches the buffer size with a completed frame
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_held) |-> (r_count < CNT_W'(BUF_DEPTH)))
        else $error("byte count at buffer size without a held frame");

    // overflow never reports the byte as stored in a frame
    a_ovf_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid |-> !(r_a_res.overflow && r_a_res.byte_accepted))
        else $error("overflow and accepted in one result");

    // a stale drop restarts the hunt, so no frame can be ready
    a_stale_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && r_a_res.stale_dropped) |-> !r_a_res.frame_ready)
        else $error("frame ready right after a stale drop");

    // a nonzero position without acceptance only comes from overflow
    a_pos_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && !r_a_res.byte_accepted && (r_a_res.byte_position != '0))
        |-> r_a_res.overflow)
        else $error("unexplained byte position");

endmodule

`default_nettype wire

// File: hw/rtl/dle_stx_frame_receiver.sv
// top level of the framed serial receiver: stream ports, register port, output stage
`default_nettype none

// Collects serial bytes of DLE/STX framed messages into a 1024-byte buffer, checks
// the header, target filter, length and trailer, and holds a completed frame until
// a release word arrives or a later byte finds it at least abort_time ticks old.
// Every input word yields exactly one result word. A word is accepted in every
// clock cycle while the output side keeps up; the result passes through one stage
// that computes the frame state and reads the buffer, then through the output
// register. The buffer is a single memory with one write and one registered read
// per cycle; no clearing pass is needed after reset.
module dle_stx_frame_receiver (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // slave side
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // rx_byte[7:0], read_index[17:8], zero fill above
    input  wire logic [dsfr_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // action[1:0]
    input  wire logic [dsfr_pkg::IN_USER_W-1:0]      s_axis_tuser,
    // master side
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // byte_accepted[0], byte_position[10:1], frame_ready[11], frame_length[22:12],
    // stale_dropped[23], overflow[24], read_data[32:25], zero fill above
    output logic [dsfr_pkg::OUT_DATA_W-1:0]          m_axis_tdata,
    // register port
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [dsfr_pkg::CFG_AW-1:0]         paddr,
    input  wire logic [31:0]                         pwdata,
    output logic [31:0]                              prdata,
    output logic                                     pready
);
    import dsfr_pkg::*;

    t_cfg       r_cfg;
    logic [2:0] reg_idx;
    logic       cfg_wr;

    logic       take;
    logic       pop;
    logic       res_valid;
    t_result    res;

    logic       r_o_valid;
    t_result    r_o_res;

    // register port
    assign pready  = 1'b1;
    assign reg_idx = paddr[CFG_AW-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.abort_time   <= RST_ABORT_TIME;
            r_cfg.dle_code     <= RST_DLE_CODE;
            r_cfg.stx_code     <= RST_STX_CODE;
            r_cfg.etx_code     <= RST_ETX_CODE;
            r_cfg.group_target <= RST_GROUP_TARGET;
            r_cfg.object_first <= RST_OBJECT_FIRST;
            r_cfg.object_count <= RST_OBJECT_COUNT;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_ABORT_TIME:   r_cfg.abort_time   <= pwdata[15:0];
                REG_DLE_CODE:     r_cfg.dle_code     <= pwdata[7:0];
                REG_STX_CODE:     r_cfg.stx_code     <= pwdata[7:0];
                REG_ETX_CODE:     r_cfg.etx_code     <= pwdata[7:0];
                REG_GROUP_TARGET: r_cfg.group_target <= pwdata[7:0];
                REG_OBJECT_FIRST: r_cfg.object_first <= pwdata[7:0];
                REG_OBJECT_COUNT: r_cfg.object_count <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    // register read back
    always_comb begin
        unique case (reg_idx)
            REG_ABORT_TIME:   prdata = {16'd0, r_cfg.abort_time};
            REG_DLE_CODE:     prdata = {24'd0, r_cfg.dle_code};
            REG_STX_CODE:     prdata = {24'd0, r_cfg.stx_code};
            REG_ETX_CODE:     prdata = {24'd0, r_cfg.etx_code};
            REG_GROUP_TARGET: prdata = {24'd0, r_cfg.group_target};
            REG_OBJECT_FIRST: prdata = {24'd0, r_cfg.object_first};
            REG_OBJECT_COUNT: prdata = {24'd0, r_cfg.object_count};
            default:          prdata = '0;
        endcase
    end

    // flow control: first stage drains into the output register
    assign pop           = res_valid && (!r_o_valid || m_axis_tready);
    assign s_axis_tready = !res_valid || pop;
    assign take          = s_axis_tvalid && s_axis_tready;

    dsfr_rx_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_take       (take),
        .i_action     (t_action'(s_axis_tuser)),
        .i_rx_byte    (s_axis_tdata[7:0]),
        .i_read_index (s_axis_tdata[BUF_AW+7:8]),
        .i_pop        (pop),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (pop) begin
            r_o_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_o_res <= res;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = OUT_DATA_W'(r_o_res);

endmodule

`default_nettype wire
